FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define SLPC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("slpc check failed");

// pre holds -> post holds in the next cycle
`define SLPC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("slpc check failed");

`endif

FILE: hdl/slpc_pkg.sv
// Shared types and constants of the status LED pattern controller.
// No dependencies.
package slpc_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned HalfW = 16;
    localparam int unsigned DivW  = 17;   // widest divisor: heartbeat on + off

    // fixed pattern timing, ms
    localparam logic [TimeW-1:0] RATE_LIMIT_MS     = 32'd20;
    localparam logic [DivW-1:0]  AP_BLINK_HALF_MS  = 17'd120;
    localparam logic [DivW-1:0]  LINK_DOWN_HALF_MS = 17'd500;
    localparam logic [DivW-1:0]  HOLDOVER_HALF_MS  = 17'd200;
    localparam logic [DivW-1:0]  SEARCH_HALF_MS    = 17'd400;

    // register indexes
    localparam logic [2:0] REG_HB_ON      = 3'd0;
    localparam logic [2:0] REG_HB_OFF     = 3'd1;
    localparam logic [2:0] REG_OTA_HALF   = 3'd2;
    localparam logic [2:0] REG_TASK_STALE = 3'd3;
    localparam logic [2:0] REG_PANIC_LIM  = 3'd4;
    localparam logic [2:0] REG_PANIC_HALF = 3'd5;

    // register reset values
    localparam logic [HalfW-1:0] HB_ON_RST      = 16'd100;
    localparam logic [HalfW-1:0] HB_OFF_RST     = 16'd900;
    localparam logic [HalfW-1:0] OTA_HALF_RST   = 16'd100;
    localparam logic [TimeW-1:0] TASK_STALE_RST = 32'd10000;
    localparam logic [TimeW-1:0] PANIC_LIM_RST  = 32'd60000;
    localparam logic [HalfW-1:0] PANIC_HALF_RST = 16'd100;

    // OTA phase codes
    localparam logic [1:0] OTA_IDLE      = 2'd0;
    localparam logic [1:0] OTA_UPLOADING = 2'd1;
    localparam logic [1:0] OTA_REBOOTING = 2'd2;

    // clock state codes
    localparam logic [2:0] CLK_ACQUIRING = 3'd1;
    localparam logic [2:0] CLK_LOCKED    = 3'd2;
    localparam logic [2:0] CLK_DEGRADED  = 3'd3;
    localparam logic [2:0] CLK_HOLDOVER  = 3'd4;

    localparam logic [2:0] GNSS_ALL_GOOD = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_KICK,
        ST_PANIC,
        ST_RED,
        ST_GREEN,
        ST_DIV,
        ST_FINISH
    } slpc_state_t;

    // what a finished division feeds
    typedef enum logic [1:0] {
        JOB_OTA,
        JOB_PANIC,
        JOB_RED,
        JOB_GREEN
    } slpc_job_t;

    // blink divisor: a zero half period acts as one
    function automatic logic [DivW-1:0] blink_div(input logic [HalfW-1:0] half);
        blink_div = (half == '0) ? DivW'(1) : {1'b0, half};
    endfunction

endpackage

FILE: hdl/status_led_pattern_controller.sv
// Status LED pattern controller: all sequencing and the shared datapath.
// Depends on slpc_pkg.
//
// Usage:
//  s_* channel: one status sample per word (time, link, GNSS, OTA, task kicks).
//  m_* channel: one result word per sample: red/green/blue lamp state, restart
//   request and an evaluated flag (0 when the sample came within 20 ms of the
//   last evaluated one; lamps then hold).
//  cfg_* channel: register writes, always ready; index 0..5, others ignored.
//   Write only while no sample is in flight.
// Flow: one sample at a time. A rate-limited or rebooting sample goes straight
//  to the result word. Others run a shared 32-step restoring divider up to
//  twice, plus sequencer states for compares on one shared subtractor: the OTA
//  blink path and the panic path divide once, the normal path up to twice.
// Reset: registers take their default values, lamps off, no panic timer, last
//  evaluated time 0, output word empty.
// Stall: a finished word waits in the output register; the next sample is
//  accepted meanwhile, and its result waits until the previous word is taken.
module status_led_pattern_controller
    import slpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ms,
    input  logic        s_ap_mode,
    input  logic        s_wifi_ok,
    input  logic [2:0]  s_gnss_flags,
    input  logic [2:0]  s_clock_state,
    input  logic [5:0]  s_satellites,
    input  logic [1:0]  s_ota_phase,
    input  logic        s_ota_guard,
    input  logic [31:0] s_kick_time_ms,
    input  logic [31:0] s_kick_net_ms,
    input  logic [31:0] s_kick_ui_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_red_on,
    output logic        m_green_on,
    output logic        m_blue_on,
    output logic        m_restart_request,
    output logic        m_evaluated,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic [HalfW-1:0] hb_on_reg, hb_off_reg, ota_half_reg, panic_half_reg;
    logic [TimeW-1:0] stale_reg, panic_lim_reg;

    // sample
    logic [TimeW-1:0] now_reg, kick_time_reg, kick_net_reg, kick_ui_reg;
    logic             ap_reg, wifi_reg, guard_reg;
    logic [2:0]       gnss_reg, clk_reg;
    logic [5:0]       sats_reg;
    logic [1:0]       ota_reg;

    // block state
    slpc_state_t      state_reg, state_next;
    logic [TimeW-1:0] last_update_reg, last_update_next;
    logic [TimeW-1:0] panic_start_reg, panic_start_next;
    logic             red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic             restart_reg, restart_next, eval_reg, eval_next;
    logic [1:0]       kick_idx_reg, kick_idx_next;

    // divider
    logic [TimeW-1:0] dvd_reg, dvd_next;
    logic [DivW-1:0]  rem_reg, rem_next, divisor_reg, divisor_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             heart_reg, heart_next;
    slpc_job_t        job_reg, job_next;

    // output word
    logic m_valid_reg, m_valid_next;
    logic out_red_reg, out_green_reg, out_blue_reg, out_restart_reg, out_eval_reg;

    // shared subtract and compare
    logic [TimeW-1:0] sub_b, sub_thr, diff;
    logic             diff_ge, diff_gt;

    always_comb begin
        sub_b   = last_update_reg;
        sub_thr = RATE_LIMIT_MS;
        unique case (state_reg)
            ST_KICK: begin
                sub_thr = stale_reg;
                unique case (kick_idx_reg)
                    2'd0:    sub_b = kick_time_reg;
                    2'd1:    sub_b = kick_net_reg;
                    default: sub_b = kick_ui_reg;
                endcase
            end
            ST_PANIC: begin
                sub_b   = panic_start_reg;
                sub_thr = panic_lim_reg;
            end
            default: begin
                sub_b   = last_update_reg;
                sub_thr = RATE_LIMIT_MS;
            end
        endcase
    end

    assign diff    = now_reg - sub_b;
    assign diff_ge = diff >= sub_thr;
    assign diff_gt = diff_ge && (diff != sub_thr);

    // divider step
    logic [DivW:0]   rem_shift, rem_sub;
    logic            div_fit, div_last, div_lit;
    logic [DivW-1:0] hb_period;
    logic            period_zero, kicks_present, green_hb, green_search;
    logic            out_free;

    assign rem_shift = {rem_reg, dvd_reg[TimeW-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign div_fit   = rem_shift >= {1'b0, divisor_reg};
    assign div_last  = (cnt_reg == 5'd31);
    // blink: lit on even quotient; heartbeat: lit while remainder below on time
    assign div_lit   = heart_reg ? ((div_fit ? rem_sub[DivW-1:0] : rem_shift[DivW-1:0])
                                    < {1'b0, hb_on_reg})
                                 : !div_fit;

    assign hb_period     = {1'b0, hb_on_reg} + {1'b0, hb_off_reg};
    assign period_zero   = (hb_period == '0);
    assign kicks_present = (kick_time_reg != '0) && (kick_net_reg != '0)
                           && (kick_ui_reg != '0);
    assign green_hb      = (gnss_reg == GNSS_ALL_GOOD)
                           && (clk_reg == CLK_LOCKED || clk_reg == CLK_DEGRADED);
    assign green_search  = gnss_reg[0] || (sats_reg != '0) || (clk_reg == CLK_ACQUIRING);
    assign out_free      = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_RATE;
            end
            ST_RATE: begin
                priority if (!diff_ge)                    state_next = ST_FINISH;
                else if (ota_reg == OTA_REBOOTING)        state_next = ST_FINISH;
                else if (ota_reg != OTA_IDLE)             state_next = ST_DIV;
                else if (guard_reg || !kicks_present)     state_next = ST_RED;
                else                                      state_next = ST_KICK;
            end
            ST_KICK: begin
                priority if (diff_gt)             state_next = ST_PANIC;
                else if (kick_idx_reg == 2'd2)    state_next = ST_RED;
                else                              state_next = ST_KICK;
            end
            ST_PANIC: state_next = ST_DIV;
            ST_RED: begin
                if (wifi_reg && period_zero) state_next = ST_GREEN;
                else                         state_next = ST_DIV;
            end
            ST_GREEN: begin
                priority if (green_hb)             state_next = period_zero ? ST_FINISH : ST_DIV;
                else if (clk_reg == CLK_HOLDOVER)  state_next = ST_DIV;
                else if (green_search)             state_next = ST_DIV;
                else                               state_next = ST_FINISH;
            end
            ST_DIV: begin
                if (div_last) state_next = (job_reg == JOB_RED) ? ST_GREEN : ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        last_update_next = last_update_reg;
        panic_start_next = panic_start_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        restart_next     = restart_reg;
        eval_next        = eval_reg;
        kick_idx_next    = kick_idx_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        divisor_next     = divisor_reg;
        cnt_next         = cnt_reg;
        heart_next       = heart_reg;
        job_next         = job_reg;

        unique case (state_reg)
            ST_IDLE: begin
                restart_next = 1'b0;
                eval_next    = 1'b0;
            end
            ST_RATE: begin
                rem_next      = '0;
                cnt_next      = '0;
                dvd_next      = now_reg;
                heart_next    = 1'b0;
                job_next      = JOB_OTA;
                divisor_next  = blink_div(ota_half_reg);
                kick_idx_next = 2'd0;
                if (diff_ge) begin
                    eval_next        = 1'b1;
                    last_update_next = now_reg;
                    if (ota_reg != OTA_IDLE) begin
                        panic_start_next = '0;
                        if (ota_reg == OTA_REBOOTING) begin
                            red_next   = 1'b0;
                            green_next = 1'b1;
                            blue_next  = 1'b0;
                        end
                    end
                end
            end
            ST_KICK: begin
                kick_idx_next = kick_idx_reg + 2'd1;
            end
            ST_PANIC: begin
                // a stored start of zero means the timer is not running
                if (panic_start_reg == '0) panic_start_next = now_reg;
                else if (diff_ge)          restart_next     = 1'b1;
                divisor_next = blink_div(panic_half_reg);
                job_next     = JOB_PANIC;
            end
            ST_RED: begin
                panic_start_next = '0;
                blue_next  = (clk_reg == CLK_LOCKED) || (clk_reg == CLK_DEGRADED)
                             || (clk_reg == CLK_HOLDOVER);
                job_next   = JOB_RED;
                heart_next = wifi_reg;
                priority if (wifi_reg) begin
                    divisor_next = hb_period;
                    if (period_zero) red_next = 1'b0;
                end else if (ap_reg) begin
                    divisor_next = AP_BLINK_HALF_MS;
                end else begin
                    divisor_next = LINK_DOWN_HALF_MS;
                end
            end
            ST_GREEN: begin
                rem_next   = '0;
                cnt_next   = '0;
                dvd_next   = now_reg;
                job_next   = JOB_GREEN;
                heart_next = 1'b0;
                priority if (green_hb) begin
                    heart_next   = 1'b1;
                    divisor_next = hb_period;
                    dvd_next     = now_reg + {{(TimeW-HalfW+1){1'b0}}, hb_on_reg[HalfW-1:1]};
                    if (period_zero) green_next = 1'b0;
                end else if (clk_reg == CLK_HOLDOVER) begin
                    divisor_next = HOLDOVER_HALF_MS;
                end else if (green_search) begin
                    divisor_next = SEARCH_HALF_MS;
                end else begin
                    green_next = 1'b0;
                end
            end
            ST_DIV: begin
                rem_next = div_fit ? rem_sub[DivW-1:0] : rem_shift[DivW-1:0];
                dvd_next = {dvd_reg[TimeW-2:0], div_fit};
                cnt_next = cnt_reg + 5'd1;
                if (div_last) begin
                    unique case (job_reg)
                        JOB_OTA: begin
                            red_next   = div_lit;
                            green_next = (ota_reg == OTA_UPLOADING) && div_lit;
                            blue_next  = 1'b0;
                        end
                        JOB_PANIC: begin
                            red_next   = div_lit;
                            green_next = !div_lit;
                            blue_next  = 1'b0;
                        end
                        JOB_RED:   red_next   = div_lit;
                        JOB_GREEN: green_next = div_lit;
                    endcase
                end
            end
            ST_FINISH: begin
            end
        endcase
    end

    // output word
    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == ST_FINISH && out_free) m_valid_next = 1'b1;
        else if (m_ready)                       m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            last_update_reg <= '0;
            panic_start_reg <= '0;
            red_reg         <= 1'b0;
            green_reg       <= 1'b0;
            blue_reg        <= 1'b0;
            restart_reg     <= 1'b0;
            eval_reg        <= 1'b0;
            kick_idx_reg    <= '0;
            cnt_reg         <= '0;
            job_reg         <= JOB_OTA;
            hb_on_reg       <= HB_ON_RST;
            hb_off_reg      <= HB_OFF_RST;
            ota_half_reg    <= OTA_HALF_RST;
            stale_reg       <= TASK_STALE_RST;
            panic_lim_reg   <= PANIC_LIM_RST;
            panic_half_reg  <= PANIC_HALF_RST;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            last_update_reg <= last_update_next;
            panic_start_reg <= panic_start_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            restart_reg     <= restart_next;
            eval_reg        <= eval_next;
            kick_idx_reg    <= kick_idx_next;
            cnt_reg         <= cnt_next;
            job_reg         <= job_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_HB_ON:      hb_on_reg      <= cfg_data[HalfW-1:0];
                    REG_HB_OFF:     hb_off_reg     <= cfg_data[HalfW-1:0];
                    REG_OTA_HALF:   ota_half_reg   <= cfg_data[HalfW-1:0];
                    REG_TASK_STALE: stale_reg      <= cfg_data;
                    REG_PANIC_LIM:  panic_lim_reg  <= cfg_data;
                    REG_PANIC_HALF: panic_half_reg <= cfg_data[HalfW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        heart_reg   <= heart_next;
        if (state_reg == ST_IDLE && s_valid) begin
            now_reg       <= s_now_ms;
            ap_reg        <= s_ap_mode;
            wifi_reg      <= s_wifi_ok;
            gnss_reg      <= s_gnss_flags;
            clk_reg       <= s_clock_state;
            sats_reg      <= s_satellites;
            ota_reg       <= s_ota_phase;
            guard_reg     <= s_ota_guard;
            kick_time_reg <= s_kick_time_ms;
            kick_net_reg  <= s_kick_net_ms;
            kick_ui_reg   <= s_kick_ui_ms;
        end
        if (state_reg == ST_FINISH && out_free) begin
            out_red_reg     <= red_reg;
            out_green_reg   <= green_reg;
            out_blue_reg    <= blue_reg;
            out_restart_reg <= restart_reg;
            out_eval_reg    <= eval_reg;
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_red_on          = out_red_reg;
    assign m_green_on        = out_green_reg;
    assign m_blue_on         = out_blue_reg;
    assign m_restart_request = out_restart_reg;
    assign m_evaluated       = out_eval_reg;

endmodule

FILE: hdl/slpc_checker.sv
// Port-level checks of the status LED pattern controller, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module slpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_red_on,
    input logic        m_green_on,
    input logic        m_blue_on,
    input logic        m_restart_request,
    input logic        m_evaluated
);

    // a stalled result word stays and holds
    `SLPC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)
    `SLPC_ASSERT_NEXT(a_out_stable, m_valid && !m_ready,
        $stable(m_red_on) && $stable(m_green_on) && $stable(m_blue_on)
        && $stable(m_restart_request) && $stable(m_evaluated))

    // one sample at a time: busy right after an accept
    `SLPC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // restart only on an evaluated sample, with the panic pattern showing
    `SLPC_ASSERT_NOW(a_restart_eval, m_valid && m_restart_request, m_evaluated)
    `SLPC_ASSERT_NOW(a_restart_panic, m_valid && m_restart_request,
        (m_red_on != m_green_on) && !m_blue_on)

endmodule

bind status_led_pattern_controller slpc_checker u_slpc_checker (.*);
